FILE: rtl/core/mau_pkg.sv
// Package for the modular arithmetic unit: widths, opcodes, status codes,
// payload structs and sequencer states. No dependencies.
`default_nettype none
package mau_pkg;
   localparam int unsigned WIDTH = 32;
   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   typedef enum logic [2:0] {
      OP_REDUCE = 3'd0, OP_NEGATE = 3'd1, OP_ADD = 3'd2, OP_SUB = 3'd3,
      OP_MUL = 3'd4, OP_INV = 3'd5, OP_POW = 3'd6, OP_NONE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_INV_ZERO = 2'd1, ST_NOT_COPRIME = 2'd2, ST_RSVD = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0] operation;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] residue;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_MUL_RUN, S_POW_STEP, S_POW_MUL,
      S_POW_SQ, S_INV_DIV, S_INV_QMOD, S_INV_MUL, S_INV_UPD, S_INV_END, S_DONE
   } state_type;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIDTH);
endpackage
`default_nettype wire

FILE: rtl/core/mau_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on mau_pkg.
`default_nettype none
module mau_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        go,
   input  wire logic [mau_pkg::WIDTH-1:0]   dividend,
   input  wire logic [mau_pkg::WIDTH-1:0]   divisor,
   output logic                             done,
   output logic [mau_pkg::WIDTH-1:0]        quotient,
   output logic [mau_pkg::WIDTH-1:0]        remainder
);
   import mau_pkg::*;
   logic [WIDTH-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[WIDTH-1]};
      if (go) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CNT_FULL; run_in = 1'b1;
      end else if (run_ff) begin
         // shift one dividend bit in, subtract when it fits
         if (trial >= {1'b0, d_ff}) begin
            r_in = WIDTH'(trial - {1'b0, d_ff});
            q_in = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            r_in = trial[WIDTH-1:0];
            q_in = {q_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

FILE: rtl/core/mau_mulmod.sv
// Shift-add modular multiplier, one multiplier bit per cycle, MSB first.
// Depends on mau_pkg. Inputs must already lie below the modulus.
`default_nettype none
module mau_mulmod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        go,
   input  wire logic [mau_pkg::WIDTH-1:0]   x,
   input  wire logic [mau_pkg::WIDTH-1:0]   y,
   input  wire logic [mau_pkg::WIDTH-1:0]   m,
   output logic                             done,
   output logic [mau_pkg::WIDTH-1:0]        product
);
   import mau_pkg::*;
   logic [WIDTH-1:0] acc_ff, acc_in, x_ff, x_in, y_ff, y_in, m_ff, m_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [WIDTH:0]   dbl, dblr, sum;
   logic [WIDTH-1:0] dred;

   always_comb begin
      acc_in = acc_ff; x_in = x_ff; y_in = y_ff; m_in = m_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      dbl  = {acc_ff, 1'b0};
      dblr = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      dred = dblr[WIDTH-1:0];
      sum  = {1'b0, dred} + {1'b0, x_ff};
      if (go) begin
         acc_in = '0; x_in = x; y_in = y; m_in = m;
         cnt_in = CNT_FULL; run_in = 1'b1;
      end else if (run_ff) begin
         // double, then add the multiplicand when the top bit is set
         if (y_ff[WIDTH-1])
            acc_in = (sum >= {1'b0, m_ff}) ? WIDTH'(sum - {1'b0, m_ff}) : sum[WIDTH-1:0];
         else
            acc_in = dred;
         y_in = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; x_ff <= x_in; y_ff <= y_in; m_ff <= m_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: rtl/core/modular_arithmetic_unit.sv
// Modular ALU: reduce, negate, add, subtract, multiply, inverse, power.
// Reduce/negate/add/sub run two divides (reducing a and b) from accept to strobe;
// multiply adds one multiply; power adds up to 62 multiplies on the shared multiplier;
// inverse adds two divides and a multiply per Euclid step. One item at a time; busy
// stays high through the result strobe. Reset clears control, sets modulus to 1.
// Depends on mau_pkg, mau_divider, mau_mulmod.
`default_nettype none
module modular_arithmetic_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire mau_pkg::req_type   req_data,
   output logic                    rsp_valid,
   output mau_pkg::rsp_type        rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [1:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import mau_pkg::*;

   localparam logic [1:0] ADDR_MODULUS = 2'd0;

   // Configuration register
   logic [31:0] modulus_ff;
   logic        csr_wr;
   assign csr_wr = psel & penable & pwrite & pready;
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_MODULUS) ? modulus_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= 32'd1;
      else if (csr_wr && paddr == ADDR_MODULUS) modulus_ff <= pwdata;
   end

   // Sequencer state and working registers
   state_type        state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [WIDTH-1:0] m_ff, m_in, a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0] rawa_ff, rawa_in, rawb_ff, rawb_in;
   logic [WIDTH-1:0] acc_ff, acc_in, e_ff, e_in;
   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [WIDTH-1:0] q_ff, q_in, nr_ff, nr_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [1:0]       st_ff, st_in;
   logic             ina_neg;

   // Shared divider and multiplier control
   logic             div_go, div_done, mul_go, mul_done;
   logic [WIDTH-1:0] div_n, div_d, div_q, div_r, mul_x, mul_y, mul_p;
   logic [WIDTH-1:0] mag_a, mag_b, one_m;
   logic [WIDTH:0]   s_add;
   logic [WIDTH-1:0] v_add, v_sub, v_neg;

   mau_divider u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q), .remainder(div_r)
   );
   mau_mulmod u_mul (
      .clock(clock), .reset(reset), .go(mul_go), .x(mul_x), .y(mul_y),
      .m(m_ff), .done(mul_done), .product(mul_p)
   );

   assign mag_a = rawa_ff[WIDTH-1] ? WIDTH'(-rawa_ff) : rawa_ff;
   assign mag_b = rawb_ff[WIDTH-1] ? WIDTH'(-rawb_ff) : rawb_ff;
   assign one_m = (m_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
   assign s_add = {1'b0, a_ff} + {1'b0, b_ff};
   assign v_add = (s_add >= {1'b0, m_ff}) ? WIDTH'(s_add - {1'b0, m_ff}) : s_add[WIDTH-1:0];
   assign v_sub = (a_ff >= b_ff) ? a_ff - b_ff : a_ff + (m_ff - b_ff);
   assign v_neg = (a_ff == '0) ? '0 : m_ff - a_ff;
   assign ina_neg = rawa_ff[WIDTH-1];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start) state_in = S_RED_A;
         S_RED_A:    if (div_done) state_in = S_RED_B;
         S_RED_B:    if (div_done) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (op_type'(op_ff))
               OP_MUL:  state_in = S_MUL_RUN;
               OP_POW:  state_in = S_POW_STEP;
               OP_INV:  state_in = (rawa_ff == '0) ? S_DONE : S_INV_DIV;
               default: state_in = S_DONE;
            endcase
         end
         S_MUL_RUN:  if (mul_done) state_in = S_DONE;
         S_POW_STEP: begin
            if (e_ff == '0) state_in = S_DONE;
            else if (e_ff[0]) state_in = S_POW_MUL;
            else state_in = S_POW_SQ;
         end
         S_POW_MUL:  if (mul_done) state_in = S_POW_SQ;
         S_POW_SQ:   if (mul_done) state_in = S_POW_STEP;
         S_INV_DIV:  if (r1_ff == '0) state_in = S_INV_END;
                     else if (div_done) state_in = S_INV_QMOD;
         S_INV_QMOD: if (div_done) state_in = S_INV_MUL;
         S_INV_MUL:  if (mul_done) state_in = S_INV_UPD;
         S_INV_UPD:  state_in = S_INV_DIV;
         S_INV_END:  state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Unit launches: fire on the cycle a state is entered
   logic enter;
   state_type prev_ff;
   assign enter = (state_ff != prev_ff);

   always_comb begin
      div_go = 1'b0; div_n = mag_a; div_d = m_ff;
      mul_go = 1'b0; mul_x = a_ff; mul_y = b_ff;
      unique case (state_ff)
         S_RED_A:    begin div_go = enter; div_n = mag_a; end
         S_RED_B:    begin div_go = enter; div_n = mag_b; end
         S_MUL_RUN:  mul_go = enter;
         // power keeps its running base in a
         S_POW_MUL:  begin mul_go = enter; mul_x = acc_ff; mul_y = a_ff; end
         S_POW_SQ:   begin mul_go = enter; mul_x = a_ff; mul_y = a_ff; end
         S_INV_DIV:  begin div_go = enter && r1_ff != '0; div_n = r0_ff; div_d = r1_ff; end
         S_INV_QMOD: begin div_go = enter; div_n = q_ff; div_d = m_ff; end
         S_INV_MUL:  begin mul_go = enter; mul_x = q_ff; mul_y = t1_ff; end
         default: ;
      endcase
   end

   // Datapath registers
   always_comb begin
      op_in = op_ff; m_in = m_ff; a_in = a_ff; b_in = b_ff;
      rawa_in = rawa_ff; rawb_in = rawb_ff; acc_in = acc_ff; e_in = e_ff;
      r0_in = r0_ff; r1_in = r1_ff; t0_in = t0_ff; t1_in = t1_ff;
      q_in = q_ff; nr_in = nr_ff; res_in = res_ff; st_in = st_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            op_in = req_data.operation;
            rawa_in = req_data.operand_a; rawb_in = req_data.operand_b;
            // zero modulus acts as one
            m_in = (modulus_ff == '0) ? WIDTH'(1) : modulus_ff;
         end
         S_RED_A: if (div_done)
            a_in = (ina_neg && div_r != '0) ? m_ff - div_r : div_r;
         S_RED_B: if (div_done)
            b_in = (rawb_ff[WIDTH-1] && div_r != '0) ? m_ff - div_r : div_r;
         S_DISPATCH: begin
            res_in = '0; st_in = ST_OK;
            acc_in = one_m;
            e_in = rawb_ff[WIDTH-1] ? '0 : rawb_ff;
            // inverse runs on |a| mod m
            r0_in = m_ff; r1_in = ina_neg ? v_neg : a_ff; t0_in = '0; t1_in = one_m;
            unique case (op_type'(op_ff))
               OP_REDUCE: res_in = a_ff;
               OP_NEGATE: res_in = v_neg;
               OP_ADD:    res_in = v_add;
               OP_SUB:    res_in = v_sub;
               OP_INV:    if (rawa_ff == '0) st_in = ST_INV_ZERO;
               default: ;
            endcase
         end
         S_MUL_RUN:  if (mul_done) res_in = mul_p;
         S_POW_STEP: begin
            if (e_ff == '0) res_in = acc_ff;
            e_in = e_ff;
         end
         S_POW_MUL:  if (mul_done) acc_in = mul_p;
         S_POW_SQ:   if (mul_done) begin a_in = mul_p; e_in = e_ff >> 1; end
         S_INV_DIV:  if (div_done) begin q_in = div_q; nr_in = div_r; end
         S_INV_QMOD: if (div_done) q_in = div_r;
         S_INV_MUL:  if (mul_done) q_in = mul_p;
         S_INV_UPD: begin
            // t_new = t0 - q*t1 mod m
            t1_in = (t0_ff >= q_ff) ? t0_ff - q_ff : t0_ff + (m_ff - q_ff);
            t0_in = t1_ff; r0_in = r1_ff; r1_in = nr_ff;
         end
         S_INV_END: begin
            if (r0_ff != WIDTH'(1)) begin
               st_in = ST_NOT_COPRIME; res_in = '0;
            end else if (ina_neg) res_in = (t0_ff == '0) ? '0 : m_ff - t0_ff;
            else res_in = t0_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; m_ff <= m_in; a_ff <= a_in; b_ff <= b_in;
      rawa_ff <= rawa_in; rawb_ff <= rawb_in; acc_ff <= acc_in; e_ff <= e_in;
      r0_ff <= r0_in; r1_ff <= r1_in; t0_ff <= t0_in; t1_ff <= t1_in;
      q_ff <= q_in; nr_ff <= nr_in; res_ff <= res_in; st_ff <= st_in;
      if (reset) begin
         state_ff <= S_IDLE; prev_ff <= S_IDLE;
      end else begin
         state_ff <= state_in; prev_ff <= state_ff;
      end
   end

   // Outputs: one-cycle result beat in S_DONE
   always_comb begin
      busy = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      rsp_data.residue = res_ff;
      rsp_data.status = st_ff;
   end
endmodule
`default_nettype wire

FILE: rtl/core/mau_checker.sv
// Port-level checker for modular_arithmetic_unit, bound to the top level.
// Depends on mau_pkg.
`default_nettype none
module mau_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire mau_pkg::rsp_type rsp_data,
   input wire logic             pready
);
   import mau_pkg::*;
   a_idle_after_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result beat");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.residue == '0)
      else $error("nonzero residue on error");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != ST_RSVD) else $error("bad status");
   a_pready: assert property (@(posedge clock) pready) else $error("pready low");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data), .pready(pready)
);
`default_nettype wire
